>>> rtl/core/lsa_pkg.sv
package lsa_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic REG_ALLOC_CLASS = 1'b0;
  localparam logic REG_POOL_COUNT  = 1'b1;

  localparam logic VERDICT_ASSIGN = 1'b0;
  localparam logic VERDICT_SPILL  = 1'b1;

  localparam logic [4:0] POOL_COUNT_RESET = 5'd16;

  localparam int VID_W  = 16;
  localparam int POS_W  = 16;
  localparam int PIN_W  = 16;
  localparam int SLOT_W = 4;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;

endpackage

>>> rtl/core/linear_scan_slot_allocator.sv
// Linear-scan slot allocator: takes live intervals sorted by start and answers each interval of
// the handled class with one result (slot assigned or spilled), or with two when an active entry
// is evicted (the evicted value first, tlast low, then the new interval's verdict, tlast high).
// Intervals of the other class give no result; their restart flag still clears the table. One
// comparator walks the active table one slot per cycle, expiring entries and tracking the
// eviction candidate; the pick state then gives the first result, and the retry state the new
// interval's verdict after an eviction; a skipped interval leaves the sequencer idle. in_tready
// is high only while the sequencer is idle. The free-slot pick is a priority encoder over the
// table's valid bits, the pinned mask and the pool count.
module linear_scan_slot_allocator
  import lsa_pkg::*;
#(
  parameter int POOL_SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: value_id, live_start, live_end, pinned_mask
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: restart, reg_class
  input  logic [1:0]            in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: out_value_id, slot, zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // tuser: verdict
  output logic                  out_tuser,
  output logic                  out_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SW = $clog2(POOL_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(POOL_SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_PICK  = 2'd2;
  localparam logic [1:0] S_RETRY = 2'd3;

  logic [1:0]            state_r;
  logic                  alloc_class_r;
  logic [4:0]            pool_count_r;

  logic [POOL_SLOTS-1:0] valid_r;
  logic [VID_W-1:0]      value_r [POOL_SLOTS];
  logic [POS_W-1:0]      end_r   [POOL_SLOTS];

  logic [VID_W-1:0]      vid_r;
  logic [POS_W-1:0]      start_r;
  logic [POS_W-1:0]      lend_r;
  logic [PIN_W-1:0]      pin_r;
  logic [SW-1:0]         idx_r;
  logic [SW-1:0]         vic_r;
  logic                  vic_found_r;
  logic [POS_W-1:0]      vic_end_r;

  logic                  out_valid_r;
  logic [VID_W-1:0]      out_vid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_verdict_r;
  logic                  out_last_r;

  logic                  cfg_wr;
  logic                  in_xfer;
  logic                  out_free;
  logic                  out_load;
  logic [POOL_SLOTS-1:0] pin_vec;
  logic [POOL_SLOTS-1:0] in_pool;
  logic [POOL_SLOTS-1:0] free_vec;
  logic [SW-1:0]         pick_idx;
  logic                  pick_found;
  logic [POS_W-1:0]      cur_end;
  logic                  cur_expire;
  logic                  cur_better;
  logic                  wr_en;
  logic                  evict;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - VID_W - SLOT_W){1'b0}}, out_slot_r, out_vid_r};
  assign out_tuser  = out_verdict_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ALLOC_CLASS: cfg_prdata = CFG_DATA_W'(alloc_class_r);
      REG_POOL_COUNT:  cfg_prdata = CFG_DATA_W'(pool_count_r);
      default:         cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_class_r <= 1'b0;
      pool_count_r  <= POOL_COUNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ALLOC_CLASS: alloc_class_r <= cfg_pwdata[0];
        REG_POOL_COUNT:  pool_count_r  <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  // lowest free slot inside the pool
  always_comb begin
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      pin_vec[i] = (i < PIN_W) ? pin_r[4'(i)] : 1'b0;
      in_pool[i] = (6'(i) < {1'b0, pool_count_r});
    end
    free_vec = ~valid_r & ~pin_vec & in_pool;
    for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        pick_idx   = SW'(i);
        pick_found = 1'b1;
      end
    end
  end

  // shared scan comparator
  assign cur_end    = end_r[idx_r];
  assign cur_expire = valid_r[idx_r] & (cur_end < start_r);
  assign cur_better = valid_r[idx_r] & ~cur_expire & (~vic_found_r | (cur_end >= vic_end_r));

  assign evict    = vic_found_r & (vic_end_r > lend_r);
  assign out_load = ((state_r == S_PICK) || (state_r == S_RETRY)) & out_free;
  assign wr_en    = out_load & pick_found;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_r[pick_idx] <= vid_r;
      end_r[pick_idx]   <= lend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vid_r   <= in_tdata[15:0];
      start_r <= in_tdata[31:16];
      lend_r  <= in_tdata[47:32];
      pin_r   <= in_tdata[63:48];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      valid_r       <= '0;
      idx_r         <= '0;
      vic_r         <= '0;
      vic_found_r   <= 1'b0;
      vic_end_r     <= '0;
      out_valid_r   <= 1'b0;
      out_vid_r     <= '0;
      out_slot_r    <= '0;
      out_verdict_r <= 1'b0;
      out_last_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_tuser[0]) begin
              valid_r <= '0;
            end
            idx_r       <= '0;
            vic_found_r <= 1'b0;
            if (in_tuser[1] == alloc_class_r) begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (cur_expire) begin
            valid_r[idx_r] <= 1'b0;
          end
          if (cur_better) begin
            vic_r       <= idx_r;
            vic_end_r   <= cur_end;
            vic_found_r <= 1'b1;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= S_PICK;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PICK, S_RETRY: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (pick_found) begin
              valid_r[pick_idx] <= 1'b1;
              out_vid_r     <= vid_r;
              out_slot_r    <= SLOT_W'(pick_idx);
              out_verdict_r <= VERDICT_ASSIGN;
              out_last_r    <= 1'b1;
              state_r       <= S_IDLE;
            end else if (state_r == S_PICK && evict) begin
              valid_r[vic_r] <= 1'b0;
              out_vid_r     <= value_r[vic_r];
              out_slot_r    <= '0;
              out_verdict_r <= VERDICT_SPILL;
              out_last_r    <= 1'b0;
              state_r       <= S_RETRY;
            end else begin
              out_vid_r     <= vid_r;
              out_slot_r    <= '0;
              out_verdict_r <= VERDICT_SPILL;
              out_last_r    <= 1'b1;
              state_r       <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser[0] |=> (valid_r == '0))
    else $error("restart did not clear the active table");

  a_evict_then_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> (state_r == S_RETRY))
    else $error("eviction result pending outside retry");

  a_assign_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(pick_idx)])
    else $error("assigned slot not marked active");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (state_r == S_IDLE) && !out_valid_r)
    else $error("sequencer not idle after reset");
`endif

endmodule
